/* design/shortest_remaining_time_scheduler_assert.svh */
// Assertion macros for the scheduler.
`ifndef SHORTEST_REMAINING_TIME_SCHEDULER_ASSERT_SVH
`define SHORTEST_REMAINING_TIME_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define SRTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// next-cycle implication
`define SRTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

/* design/srts_pkg.sv */
package srts_pkg;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  slot;
    logic [15:0] arrival_time;
    logic [15:0] service_time;
  } in_item_t;

  typedef struct packed {
    logic        ran_job;
    logic [3:0]  job_slot;
    logic        job_finished;
    logic [31:0] start_time;
    logic [31:0] finish_time;
    logic [31:0] turnaround;
    logic [31:0] weighted_turnaround;
    logic        all_done;
  } out_item_t;

  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] service;
    logic [15:0] remaining;
    logic [31:0] start_time;
  } job_entry_t;

endpackage

/* design/srts_div.sv */
module srts_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [31:0] q_r;
  logic [15:0] rem_r;
  logic [15:0] dvs_r;
  logic [16:0] trial;
  logic        ge;
  logic [16:0] diff;

  assign trial = {rem_r, q_r[31]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == 5'd31);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[30:0], ge};
      rem_r <= ge ? diff[15:0] : trial[15:0];
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

/* design/shortest_remaining_time_scheduler.sv */
// Preemptive shortest-remaining-time scheduler over JOB_SLOTS job slots.
// Load, clear and unused opcodes are taken while idle and give no result.
// A tick walks the slot table one entry a cycle through the single read
// port of the job memory; when the running job completes, a bit-serial
// divider forms the weighted turnaround. The block accepts a new item
// only between ticks, but a finished result waits in the output register
// while the next item is taken.
`include "shortest_remaining_time_scheduler_assert.svh"

module shortest_remaining_time_scheduler #(
  parameter int JOB_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  srts_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output srts_pkg::out_item_t out_data
);

  localparam int SLOT_W = $clog2(JOB_SLOTS);
  localparam int CNT_W  = SLOT_W + 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_UPD  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  srts_pkg::job_entry_t mem_r [JOB_SLOTS];
  srts_pkg::job_entry_t rd_data_r;
  srts_pkg::job_entry_t mem_wdata;
  logic [SLOT_W-1:0]    mem_waddr;
  logic                 mem_we;
  logic [SLOT_W-1:0]    rd_addr;

  logic [JOB_SLOTS-1:0] loaded_r, started_r, over_r;
  logic [31:0]          time_r;

  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     pend_cnt_r;
  logic                 p_vld_r;
  logic [SLOT_W-1:0]    p_idx_r;
  logic                 found_r;
  logic [SLOT_W-1:0]    best_idx_r;
  srts_pkg::job_entry_t best_r;

  srts_pkg::out_item_t  res_r;
  srts_pkg::out_item_t  out_data_r;
  logic                 out_valid_r;

  logic        in_acc;
  logic        load_ok;
  logic        pend;
  logic        cand;
  logic        take;
  logic        scan_last;
  logic [15:0] new_rem;
  logic [31:0] start_v;
  logic [31:0] new_time;
  logic        fin;
  logic [31:0] turn;
  logic        div_start;
  logic        div_done;
  logic [31:0] div_q;
  logic        emit_go;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign load_ok  = in_acc && (in_data.opcode == srts_pkg::OP_LOAD)
                    && (32'(in_data.slot) < JOB_SLOTS);

  assign rd_addr   = cnt_r[SLOT_W-1:0];
  assign pend      = loaded_r[p_idx_r] && !over_r[p_idx_r];
  assign cand      = pend && ({16'd0, rd_data_r.arrival} <= time_r);
  assign take      = p_vld_r && cand && (!found_r || rd_data_r.remaining < best_r.remaining);
  assign scan_last = p_vld_r && (p_idx_r == SLOT_W'(JOB_SLOTS - 1));

  assign new_rem   = (best_r.remaining != 16'd0) ? best_r.remaining - 16'd1 : 16'd0;
  assign start_v   = started_r[best_idx_r] ? best_r.start_time : time_r;
  assign new_time  = (time_r == srts_pkg::TIME_MAX) ? time_r : time_r + 32'd1;
  assign fin       = found_r && (new_rem == 16'd0);
  assign turn      = new_time - {16'd0, best_r.arrival};
  assign div_start = (state_r == ST_UPD) && fin;
  assign emit_go   = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = SLOT_W'(in_data.slot);
    mem_wdata = '{arrival: in_data.arrival_time, service: in_data.service_time,
                  remaining: in_data.service_time, start_time: 32'd0};
    if (load_ok) begin
      mem_we = 1'b1;
    end else if ((state_r == ST_UPD) && found_r) begin
      mem_we    = 1'b1;
      mem_waddr = best_idx_r;
      mem_wdata = '{arrival: best_r.arrival, service: best_r.service,
                    remaining: new_rem, start_time: start_v};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_data.opcode == srts_pkg::OP_TICK)) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_last) state_nxt = ST_UPD;
      end
      ST_UPD: begin
        state_nxt = fin ? ST_DIV : ST_EMIT;
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      loaded_r    <= '0;
      started_r   <= '0;
      over_r      <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
      p_vld_r     <= 1'b0;
      found_r     <= 1'b0;
      cnt_r       <= '0;
      pend_cnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (load_ok) begin
            loaded_r[SLOT_W'(in_data.slot)]  <= 1'b1;
            started_r[SLOT_W'(in_data.slot)] <= 1'b0;
            over_r[SLOT_W'(in_data.slot)]    <= (in_data.service_time == 16'd0);
          end else if (in_acc && (in_data.opcode == srts_pkg::OP_CLEAR)) begin
            loaded_r  <= '0;
            started_r <= '0;
            over_r    <= '0;
            time_r    <= '0;
          end
          cnt_r      <= '0;
          p_vld_r    <= 1'b0;
          found_r    <= 1'b0;
          pend_cnt_r <= '0;
        end
        ST_SCAN: begin
          if (cnt_r < CNT_W'(JOB_SLOTS)) begin
            p_vld_r <= 1'b1;
            p_idx_r <= cnt_r[SLOT_W-1:0];
            cnt_r   <= cnt_r + CNT_W'(1);
          end else begin
            p_vld_r <= 1'b0;
          end
          if (p_vld_r && pend) pend_cnt_r <= pend_cnt_r + CNT_W'(1);
          if (take) begin
            found_r    <= 1'b1;
            best_idx_r <= p_idx_r;
            best_r     <= rd_data_r;
          end
        end
        ST_UPD: begin
          time_r <= new_time;
          if (found_r) started_r[best_idx_r] <= 1'b1;
          if (fin) over_r[best_idx_r] <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_UPD) begin
      res_r.ran_job             <= found_r;
      res_r.job_slot            <= found_r ? 4'(best_idx_r) : 4'd0;
      res_r.job_finished        <= fin;
      res_r.start_time          <= found_r ? start_v : 32'd0;
      res_r.finish_time         <= new_time;
      res_r.turnaround          <= fin ? turn : 32'd0;
      res_r.weighted_turnaround <= 32'd0;
      res_r.all_done            <= (pend_cnt_r == CNT_W'(fin));
    end else if ((state_r == ST_DIV) && div_done) begin
      res_r.weighted_turnaround <= (best_r.service == 16'd0) ? 32'd0 : div_q;
    end
    if (emit_go) out_data_r <= res_r;
  end

  srts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (turn),
    .divisor  (best_r.service),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SRTS_ASSERT_NOW(a_div_done_in_div, div_done, state_r == ST_DIV)
  `SRTS_ASSERT_NEXT(a_finish_divides, (state_r == ST_UPD) && fin, state_r == ST_DIV)
  `SRTS_ASSERT_NOW(a_pend_bound, 1'b1, pend_cnt_r <= CNT_W'(JOB_SLOTS))
  `SRTS_ASSERT_NOW(a_finish_ran, out_valid_r && out_data_r.job_finished, out_data_r.ran_job)

endmodule

/* test/shortest_remaining_time_scheduler_test.sv */
`timescale 1ns / 100ps

module shortest_remaining_time_scheduler_test;

  localparam int SLOTS = 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 64;
  localparam int RANDOM_ITEMS = 1150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  srts_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  srts_pkg::out_item_t out_data;

  shortest_remaining_time_scheduler #(
    .JOB_SLOTS(SLOTS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #10 clk = ~clk;

  // scheduler state as the block should hold it
  bit [31:0] clock_now;
  bit loaded [SLOTS];
  bit started [SLOTS];
  bit over [SLOTS];
  bit [15:0] arrival_of [SLOTS];
  bit [15:0] service_of [SLOTS];
  bit [15:0] remaining_of [SLOTS];
  bit [31:0] started_at [SLOTS];

  srts_pkg::out_item_t expected_ticks [$];
  int mismatches;
  int items_sent;
  bit calm;
  int hold_serial;
  int hold_seen;
  int rx_wait;
  int rx_calm_left;

  task automatic predict_schedule(input srts_pkg::in_item_t item);
    srts_pkg::out_item_t r;
    bit found;
    int pick;
    bit [15:0] best;
    r = '0;
    found = 1'b0;
    pick = 0;
    best = '0;
    case (item.opcode)
      srts_pkg::OP_LOAD: begin
        loaded[item.slot] = 1'b1;
        arrival_of[item.slot] = item.arrival_time;
        service_of[item.slot] = item.service_time;
        remaining_of[item.slot] = item.service_time;
        started[item.slot] = 1'b0;
        started_at[item.slot] = '0;
        over[item.slot] = (item.service_time == 16'd0);
      end
      srts_pkg::OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          loaded[i] = 1'b0;
          started[i] = 1'b0;
          over[i] = 1'b0;
        end
        clock_now = '0;
      end
      srts_pkg::OP_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (loaded[i] && !over[i] && {16'd0, arrival_of[i]} <= clock_now &&
              (!found || remaining_of[i] < best)) begin
            found = 1'b1;
            best = remaining_of[i];
            pick = i;
          end
        end
        if (found) begin
          if (!started[pick]) begin
            started[pick] = 1'b1;
            started_at[pick] = clock_now;
          end
          r.ran_job = 1'b1;
          r.job_slot = 4'(pick);
          r.start_time = started_at[pick];
          if (remaining_of[pick] != 16'd0) remaining_of[pick] -= 16'd1;
        end
        if (clock_now != srts_pkg::TIME_MAX) clock_now++;
        r.finish_time = clock_now;
        if (found && remaining_of[pick] == 16'd0) begin
          r.job_finished = 1'b1;
          over[pick] = 1'b1;
          r.turnaround = clock_now - {16'd0, arrival_of[pick]};
          r.weighted_turnaround = r.turnaround / {16'd0, service_of[pick]};
        end
        r.all_done = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
          if (loaded[i] && !over[i]) r.all_done = 1'b0;
        end
        expected_ticks.push_back(r);
      end
      default: begin
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_tick(input srts_pkg::out_item_t got);
    srts_pkg::out_item_t want;
    if (expected_ticks.size() == 0) begin
      $error("tick result with no tick outstanding");
      mismatches++;
      return;
    end
    want = expected_ticks.pop_front();
    compare_field("ran_job", 32'(want.ran_job), 32'(got.ran_job));
    compare_field("job_slot", 32'(want.job_slot), 32'(got.job_slot));
    compare_field("job_finished", 32'(want.job_finished), 32'(got.job_finished));
    compare_field("start_time", want.start_time, got.start_time);
    compare_field("finish_time", want.finish_time, got.finish_time);
    compare_field("turnaround", want.turnaround, got.turnaround);
    compare_field("weighted_turnaround", want.weighted_turnaround,
                  got.weighted_turnaround);
    compare_field("all_done", 32'(want.all_done), 32'(got.all_done));
  endtask

  // take results, stalling at random or for a long hold when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_tick(out_data);
        if (rx_calm_left > 0) begin
          rx_calm_left--;
          rx_wait = 0;
        end else begin
          if ($urandom_range(0, 5) == 0) rx_calm_left = $urandom_range(10, 40);
          rx_wait = $urandom_range(0, 8);
        end
      end
      if (hold_serial != hold_seen) begin
        hold_seen = hold_serial;
        rx_wait = HOLD_CYCLES;
      end
      if (rx_wait > 0) begin
        out_ready <= 1'b0;
        rx_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic srts_pkg::in_item_t make_item(input logic [1:0] op,
                                                   input logic [3:0] slot,
                                                   input logic [15:0] arr,
                                                   input logic [15:0] svc);
    srts_pkg::in_item_t item;
    item.opcode = op;
    item.slot = slot;
    item.arrival_time = arr;
    item.service_time = svc;
    return item;
  endfunction

  // hold valid across back-to-back items; drop it only for a gap
  task automatic send_item(input srts_pkg::in_item_t item);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    predict_schedule(item);
    if (item.opcode != OP_UNUSED) items_sent++;
  endtask

  task automatic run_tick;
    send_item(make_item(srts_pkg::OP_TICK, 4'($urandom), 16'($urandom), 16'($urandom)));
  endtask

  task automatic load_job(input logic [3:0] slot, input logic [15:0] arr,
                          input logic [15:0] svc);
    send_item(make_item(srts_pkg::OP_LOAD, slot, arr, svc));
  endtask

  task automatic clear_table;
    send_item(make_item(srts_pkg::OP_CLEAR, 4'($urandom), 16'($urandom), 16'($urandom)));
  endtask

  task automatic test_idle_and_unused;
    run_tick();
    run_tick();
    send_item(make_item(OP_UNUSED, 4'hF, 16'hFFFF, 16'hFFFF));
    run_tick();
  endtask

  task automatic test_load_extremes;
    clear_table();
    load_job(4'd15, 16'hFFFF, 16'hFFFF);
    load_job(4'd0, 16'd0, 16'd1);
    load_job(4'd5, 16'd0, 16'd0);
    run_tick();
    run_tick();
    load_job(4'd15, 16'd0, 16'd2);
    run_tick();
    run_tick();
  endtask

  task automatic test_preempt_and_ties;
    clear_table();
    load_job(4'd7, 16'd0, 16'd4);
    run_tick();
    load_job(4'd12, 16'd1, 16'd1);
    load_job(4'd3, 16'd1, 16'd1);
    repeat (5) run_tick();
  endtask

  task automatic test_output_backpressure;
    calm = 1'b1;
    clear_table();
    load_job(4'd1, 16'd0, 16'd3);
    load_job(4'd2, 16'd0, 16'd5);
    load_job(4'd6, 16'd1, 16'd2);
    hold_serial <= hold_serial + 1;
    repeat (14) run_tick();
    calm = 1'b0;
  endtask

  task automatic load_random_job(inout int work);
    logic [15:0] svc;
    int arr;
    arr = clock_now + $urandom_range(0, 12);
    if (arr > 65535) arr = 65535;
    svc = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
    work += int'(svc);
    load_job(4'($urandom), 16'(arr), svc);
  endtask

  task automatic test_random_schedules(input int target);
    srts_pkg::in_item_t item;
    int work;
    while (items_sent < target) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(3, 10)) begin
          item = make_item(2'($urandom_range(0, 3)), 4'($urandom), 16'($urandom),
                           16'($urandom));
          send_item(item);
        end
      end else begin
        work = 0;
        if ($urandom_range(0, 3) != 0) clear_table();
        repeat ($urandom_range(1, 6)) load_random_job(work);
        repeat (work + $urandom_range(0, 3)) begin
          if ($urandom_range(0, 9) == 0) begin
            int extra;
            extra = 0;
            load_random_job(extra);
          end
          run_tick();
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_and_unused();
    test_load_extremes();
    test_preempt_and_ties();
    test_output_backpressure();
    items_sent = 0;
    test_random_schedules(RANDOM_ITEMS);
    in_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("shortest_remaining_time_scheduler_test: done, clean");
    end else begin
      $display("shortest_remaining_time_scheduler_test: done, errors");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("shortest_remaining_time_scheduler_test: done, errors");
    $finish;
  end

endmodule

/* shortest_remaining_time_scheduler.f */
+incdir+design
design/srts_pkg.sv
design/srts_div.sv
design/shortest_remaining_time_scheduler.sv
test/shortest_remaining_time_scheduler_test.sv
